>>> sv/u8sd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and codes for the byte classifier, the rune decoder and the
// beat queues between them.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned StatWidth  = 3;
  localparam int unsigned ClsWidth   = 3;
  localparam int unsigned DataWidth  = 7;

  // Byte classes produced by the front end.
  localparam logic [ClsWidth-1:0] CLS_TERM  = 3'd0;
  localparam logic [ClsWidth-1:0] CLS_ASCII = 3'd1;
  localparam logic [ClsWidth-1:0] CLS_CONT  = 3'd2;
  localparam logic [ClsWidth-1:0] CLS_LEAD2 = 3'd3;
  localparam logic [ClsWidth-1:0] CLS_LEAD3 = 3'd4;
  localparam logic [ClsWidth-1:0] CLS_LEAD4 = 3'd5;
  localparam logic [ClsWidth-1:0] CLS_BAD   = 3'd6;

  // Result status codes.
  localparam logic [StatWidth-1:0] ST_CODE     = 3'd0;
  localparam logic [StatWidth-1:0] ST_END      = 3'd1;
  localparam logic [StatWidth-1:0] ST_BAD_LEAD = 3'd2;
  localparam logic [StatWidth-1:0] ST_BAD_CONT = 3'd3;
  localparam logic [StatWidth-1:0] ST_MID_RUNE = 3'd4;
  localparam logic [StatWidth-1:0] ST_DROPPED  = 3'd5;

  localparam logic [CountWidth-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ClsWidth-1:0]  cls;
    logic [DataWidth-1:0] data;   // payload bits of the byte, already masked
  } byte_item_t;

  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic [StatWidth-1:0]  status;
    logic [CountWidth-1:0] rune_total;
  } result_t;

endpackage
`default_nettype wire

>>> sv/u8sd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small beat queue
// Register-based first-in first-out queue with show-ahead read data.
// ----------------------------------------------------------------------------
module u8sd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  logic [Width-1:0]     mem_q [Depth];
  logic [AddrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;

  function automatic logic [AddrWidth-1:0] next_ptr(input logic [AddrWidth-1:0] ptr);
    if (ptr == AddrWidth'(Depth - 1)) begin
      return '0;
    end
    return ptr + AddrWidth'(1);
  endfunction

  assign full_o  = (cnt_q == CntWidth'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/u8sd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 byte classifier
// Sorts each incoming byte into terminator, ASCII, continuation, lead byte
// of a given length or invalid, and masks off its payload bits.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic [7:0]             in_byte_i,
  output u8sd_pkg::byte_item_t   item_o
);

  import u8sd_pkg::*;

  always_comb begin
    item_o.cls  = CLS_BAD;
    item_o.data = '0;
    if (in_byte_i == 8'h00) begin
      item_o.cls = CLS_TERM;
    end else if (!in_byte_i[7]) begin
      item_o.cls  = CLS_ASCII;
      item_o.data = in_byte_i[6:0];
    end else if (in_byte_i[7:6] == 2'b10) begin
      item_o.cls  = CLS_CONT;
      item_o.data = {1'b0, in_byte_i[5:0]};
    end else if (in_byte_i[7:5] == 3'b110) begin
      item_o.cls  = CLS_LEAD2;
      item_o.data = {2'b0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      item_o.cls  = CLS_LEAD3;
      item_o.data = {3'b0, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      item_o.cls  = CLS_LEAD4;
      item_o.data = {4'b0, in_byte_i[2:0]};
    end
  end

endmodule
`default_nettype wire

>>> sv/u8sd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 rune decoder
// Consumes classified bytes, gathers continuation bits into code points,
// counts runes against the limit and produces result beats.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    limit_we_i,
  input  logic [15:0]             limit_i,
  input  u8sd_pkg::byte_item_t    item_i,
  input  logic                    item_valid_i,
  output logic                    item_pop_o,
  input  logic                    res_full_i,
  output logic                    res_push_o,
  output u8sd_pkg::result_t       res_o
);

  import u8sd_pkg::*;

  logic [CountWidth-1:0] limit_q;
  logic [1:0]            left_q, left_d;
  logic [CpWidth-1:0]    partial_q, partial_d;
  logic                  skip_q, skip_d;
  logic [CountWidth-1:0] runes_q, runes_d;
  logic [CpWidth-1:0]    joined;
  logic [1:0]            left_dec;
  logic [CountWidth-1:0] runes_inc;
  logic                  deliver;
  logic                  finish;
  logic [CpWidth-1:0]    finish_cp;

  assign item_pop_o = item_valid_i & ~res_full_i;
  assign joined     = {partial_q[CpWidth-7:0], item_i.data[5:0]};
  assign left_dec   = left_q - 2'd1;
  assign runes_inc  = (runes_q != COUNT_MAX) ? runes_q + CountWidth'(1) : runes_q;
  assign deliver    = (runes_q < limit_q);

  always_comb begin
    left_d     = left_q;
    partial_d  = partial_q;
    skip_d     = skip_q;
    runes_d    = runes_q;
    res_push_o = 1'b0;
    res_o      = '{code_point: '0, status: ST_END, rune_total: runes_q};
    finish     = 1'b0;
    finish_cp  = '0;

    if (item_pop_o) begin
      if (item_i.cls == CLS_TERM) begin
        res_push_o = 1'b1;
        res_o.status = ((left_q != 2'd0) && !skip_q) ? ST_MID_RUNE : ST_END;
        left_d    = '0;
        partial_d = '0;
        skip_d    = 1'b0;
        runes_d   = '0;
      end else if (skip_q) begin
        // Dropping bytes until the terminator.
      end else if (left_q == 2'd0) begin
        case (item_i.cls)
          CLS_ASCII: begin
            finish    = 1'b1;
            finish_cp = CpWidth'(item_i.data);
          end
          CLS_LEAD2: begin
            left_d    = 2'd1;
            partial_d = CpWidth'(item_i.data);
          end
          CLS_LEAD3: begin
            left_d    = 2'd2;
            partial_d = CpWidth'(item_i.data);
          end
          CLS_LEAD4: begin
            left_d    = 2'd3;
            partial_d = CpWidth'(item_i.data);
          end
          default: begin
            res_push_o   = 1'b1;
            res_o.status = ST_BAD_LEAD;
            skip_d       = 1'b1;
          end
        endcase
      end else if (item_i.cls != CLS_CONT) begin
        res_push_o   = 1'b1;
        res_o.status = ST_BAD_CONT;
        left_d       = '0;
        partial_d    = '0;
        skip_d       = 1'b1;
      end else begin
        left_d    = left_dec;
        partial_d = joined;
        if (left_dec == 2'd0) begin
          finish    = 1'b1;
          finish_cp = joined;
        end
      end

      if (finish) begin
        res_push_o       = 1'b1;
        left_d           = '0;
        partial_d        = '0;
        runes_d          = runes_inc;
        res_o.rune_total = runes_inc;
        res_o.status     = deliver ? ST_CODE : ST_DROPPED;
        res_o.code_point = deliver ? finish_cp : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= COUNT_MAX;
      left_q    <= '0;
      partial_q <= '0;
      skip_q    <= 1'b0;
      runes_q   <= '0;
    end else begin
      if (limit_we_i) begin
        limit_q <= limit_i;
      end
      left_q    <= left_d;
      partial_q <= partial_d;
      skip_q    <= skip_d;
      runes_q   <= runes_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a zero-terminated UTF-8 byte stream into code points with a
// running rune count, error reports and an end-of-string beat.
//
//   Channel   Handshake              Payload
//   input     push_i / full_o        in_byte_i
//   result    pop_i / empty_o        code_point_o, status_o, rune_total_o
//   config    rune_limit_we_i        rune_limit_i
//
// One byte is accepted per cycle while full_o is low; the rune decoder
// retires one queued byte per cycle whenever the result queue has room.
// Each accepted byte is registered in the byte queue, and its result, if any,
// in the result queue; the rune decoder pops a byte and pushes its result together.
// Reset is asynchronous: both queues empty, decode state cleared, limit 65535.
// A stalled result side fills the result queue, then the byte queue, then
// raises full_o; no beat is lost.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int unsigned ByteQDepth = 2,
  parameter int unsigned ResQDepth  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  in_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [20:0] code_point_o,
  output logic [2:0]  status_o,
  output logic [15:0] rune_total_o,
  input  logic        rune_limit_we_i,
  input  logic [15:0] rune_limit_i
);

  import u8sd_pkg::*;

  localparam int unsigned ItemWidth = $bits(byte_item_t);
  localparam int unsigned ResWidth  = $bits(result_t);

  byte_item_t front_item;
  byte_item_t back_item;
  logic       bq_empty;
  logic       back_pop;
  logic       rq_full;
  logic       res_push;
  result_t    res_in;
  result_t    res_out;

  u8sd_front u_front (
    .in_byte_i (in_byte_i),
    .item_o    (front_item)
  );

  u8sd_fifo #(
    .Width (ItemWidth),
    .Depth (ByteQDepth)
  ) u_byte_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_item),
    .full_o  (full_o),
    .pop_i   (back_pop),
    .data_o  (back_item),
    .empty_o (bq_empty)
  );

  u8sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_we_i   (rune_limit_we_i),
    .limit_i      (rune_limit_i),
    .item_i       (back_item),
    .item_valid_i (~bq_empty),
    .item_pop_o   (back_pop),
    .res_full_i   (rq_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  u8sd_fifo #(
    .Width (ResWidth),
    .Depth (ResQDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .data_o  (res_out),
    .empty_o (empty_o)
  );

  assign code_point_o = res_out.code_point;
  assign status_o     = res_out.status;
  assign rune_total_o = res_out.rune_total;

endmodule
`default_nettype wire

>>> sv/u8sd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module u8sd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_o,
  input  logic        pop_i,
  input  logic [20:0] code_point_o,
  input  logic [2:0]  status_o,
  input  logic [15:0] rune_total_o
);

  import u8sd_pkg::*;

  // A waiting result beat that is not taken stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(code_point_o) && $stable(status_o)
      && $stable(rune_total_o)))
    else $error("result beat changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o <= ST_DROPPED))
    else $error("status out of range");

  // Only a delivered rune carries a code point.
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_CODE) |-> (code_point_o == '0))
    else $error("code point set on a non-rune beat");

  // A finished rune, delivered or dropped, is always counted.
  a_rune_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (status_o == ST_CODE || status_o == ST_DROPPED)) |-> (rune_total_o != '0))
    else $error("rune beat with zero count");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty_o      (empty_o),
  .pop_i        (pop_i),
  .code_point_o (code_point_o),
  .status_o     (status_o),
  .rune_total_o (rune_total_o)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds zero-terminated byte strings through the push/full side and drains
// decoded runes through the pop/empty side, both with random idle gaps. A
// scoreboard class decodes every accepted byte on its own and compares each
// popped beat with the oldest predicted one. Covered: every lead length,
// code point extremes, bad leads, bad continuations, strings cut inside a
// rune, several rune limits, and a long stall of the result side.
// ---------------------------------------------------------------------------
module testbench;
  import u8sd_pkg::*;

  class rune_scoreboard;
    logic [15:0] limit;
    logic [1:0]  bytes_left;
    logic [20:0] partial;
    bit          skipping;
    logic [15:0] runes_seen;
    result_t     due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_hits[8];

    function new();
      limit = COUNT_MAX;
      clear_string();
    endfunction

    function void set_limit(logic [15:0] value);
      limit = value;
    endfunction

    function void clear_string();
      bytes_left = '0;
      partial    = '0;
      skipping   = 1'b0;
      runes_seen = '0;
    endfunction

    function void queue_result(logic [20:0] cp, logic [2:0] st, logic [15:0] cnt);
      result_t r;
      r.code_point = cp;
      r.status     = st;
      r.rune_total = cnt;
      due.push_back(r);
    endfunction

    // A finished rune is always counted; past the limit it is only reported.
    function void close_rune(logic [20:0] cp);
      bit deliver;
      deliver = runes_seen < limit;
      if (runes_seen != COUNT_MAX) runes_seen++;
      bytes_left = '0;
      partial    = '0;
      if (deliver) queue_result(cp, ST_CODE, runes_seen);
      else queue_result('0, ST_DROPPED, runes_seen);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [15:0] cnt;
      bit          cut;
      cnt = runes_seen;
      if (b == 8'h00) begin
        cut = (bytes_left != 0) && !skipping;
        clear_string();
        queue_result('0, cut ? ST_MID_RUNE : ST_END, cnt);
        return;
      end
      if (skipping) return;
      if (bytes_left == 0) begin
        casez (b)
          8'b0???????: close_rune({14'd0, b[6:0]});
          8'b110?????: begin
            bytes_left = 2'd1;
            partial    = {16'd0, b[4:0]};
          end
          8'b1110????: begin
            bytes_left = 2'd2;
            partial    = {17'd0, b[3:0]};
          end
          8'b11110???: begin
            bytes_left = 2'd3;
            partial    = {18'd0, b[2:0]};
          end
          default: begin
            skipping = 1'b1;
            queue_result('0, ST_BAD_LEAD, cnt);
          end
        endcase
      end else if (b[7:6] != 2'b10) begin
        bytes_left = '0;
        partial    = '0;
        skipping   = 1'b1;
        queue_result('0, ST_BAD_CONT, cnt);
      end else begin
        partial    = {partial[14:0], b[5:0]};
        bytes_left = bytes_left - 2'd1;
        if (bytes_left == 0) close_rune(partial);
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 40) $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_result(logic [20:0] cp, logic [2:0] st, logic [15:0] cnt);
      result_t want;
      checked++;
      if (!$isunknown(st)) status_hits[st]++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 40) $error("unexpected beat: status %0d, count %0d", st, cnt);
        return;
      end
      want = due.pop_front();
      if (cp !== want.code_point) report("code_point", want.code_point, cp);
      if (st !== want.status) report("status", want.status, st);
      if (cnt !== want.rune_total) report("rune_total", want.rune_total, cnt);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        push_i          = 1'b0;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        pop_i           = 1'b0;
  logic        rune_limit_we_i = 1'b0;
  logic [15:0] rune_limit_i    = 16'h0000;
  logic        full_o;
  logic        empty_o;
  logic [20:0] code_point_o;
  logic [2:0]  status_o;
  logic [15:0] rune_total_o;

  rune_scoreboard runes;
  logic [7:0]     string_bytes[$];
  int unsigned    bytes_sent;
  int unsigned    limit_writes;
  int unsigned    holds_done;
  bit             hold_req;

  utf8_stream_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .in_byte_i       (in_byte_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .code_point_o    (code_point_o),
    .status_o        (status_o),
    .rune_total_o    (rune_total_o),
    .rune_limit_we_i (rune_limit_we_i),
    .rune_limit_i    (rune_limit_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      1:       return 8'($urandom_range(1, 127));
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic int unsigned rune_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    if (r < 6) return 2;
    if (r < 8) return 3;
    return 4;
  endfunction

  function automatic void add_rune(int unsigned len);
    string_bytes.push_back(lead_byte(len));
    for (int i = 1; i < len; i++) string_bytes.push_back(cont_byte());
  endfunction

  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(0, 6);
    repeat (n) string_bytes.push_back(8'($urandom_range(1, 255)));
  endfunction

  // Mostly well-formed runes; some strings end in one of the error forms.
  function automatic void build_string();
    int unsigned kind;
    int unsigned len;
    int unsigned bad;
    string_bytes.delete();
    repeat ($urandom_range(0, 10)) add_rune(rune_len());
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    if (kind < 8) begin
      string_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
      add_noise();
    end else if (kind < 16) begin
      bad = $urandom_range(1, 191);
      if (bad >= 128) bad += 64;
      string_bytes.push_back(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) string_bytes.push_back(cont_byte());
      string_bytes.push_back(8'(bad));
      add_noise();
    end else if (kind < 22) begin
      string_bytes.push_back(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) string_bytes.push_back(cont_byte());
    end else if (kind < 25) begin
      add_noise();
    end
    string_bytes.push_back(8'h00);
  endfunction

  task automatic send_byte(input logic [7:0] b, input int unsigned gap);
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (full_o);
    runes.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_string();
    bit burst;
    burst = ($urandom_range(0, 4) == 0);
    foreach (string_bytes[i]) send_byte(string_bytes[i], burst ? 0 : idle_gap());
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_string();
      send_string();
    end
  endtask

  // Bytes that end mid-rune or get skipped leave no beat behind, so a few
  // cycles pass after the last beat before the block counts as idle.
  task automatic drain();
    int unsigned waited;
    push_i <= 1'b0;
    waited = 0;
    while (runes.due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    drain();
    rune_limit_we_i <= 1'b1;
    rune_limit_i    <= value;
    @(posedge clk_i);
    rune_limit_we_i <= 1'b0;
    runes.set_limit(value);
    limit_writes++;
  endtask

  task automatic take_result();
    if (pop_i && !empty_o) runes.check_result(code_point_o, status_o, rune_total_o);
  endtask

  initial begin : result_side
    int unsigned n;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        pop_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(20, 80);
        pop_i <= 1'b1;
        repeat (n) begin
          @(posedge clk_i);
          take_result();
        end
      end else begin
        n = idle_gap();
        if (n != 0) begin
          pop_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        pop_i <= 1'b1;
        @(posedge clk_i);
        take_result();
      end
    end
  end

  initial begin : byte_side
    runes = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Code point extremes for each length, then each error form on its own.
    string_bytes = '{8'h01, 8'h7F, 8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,
                     8'h80, 8'h41, 8'h00, 8'hFF, 8'h00,
                     8'hC3, 8'h41, 8'h00, 8'hE2, 8'h82, 8'h00, 8'h00};
    send_string();

    write_limit(16'h0000);
    run_phase(150);
    write_limit(16'h0001);
    run_phase(150);
    write_limit(16'($urandom_range(2, 4)));
    run_phase(200);

    // Stall the result side while bytes keep coming so both queues fill.
    write_limit(COUNT_MAX);
    hold_req = 1'b1;
    repeat (200) send_byte(8'($urandom_range(1, 127)), 0);
    send_byte(8'h00, 0);
    run_phase(200);

    write_limit(16'($urandom_range(0, 65535)));
    run_phase(200);
    drain();

    $display("Sent %0d bytes, checked %0d beats, %0d limit writes, %0d long result stalls.",
             bytes_sent, runes.checked, limit_writes, holds_done);
    $display("Beats: %0d code, %0d dropped, %0d end, %0d bad lead, %0d bad cont, %0d cut.",
             runes.status_hits[ST_CODE], runes.status_hits[ST_DROPPED],
             runes.status_hits[ST_END], runes.status_hits[ST_BAD_LEAD],
             runes.status_hits[ST_BAD_CONT], runes.status_hits[ST_MID_RUNE]);
    if (runes.mismatches == 0 && runes.due.size() == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      if (runes.due.size() != 0) $error("%0d predicted beats never arrived", runes.due.size());
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd8_000_000);
    $error("run did not finish in time");
    $display("utf8_stream_decoder: mismatch");
    $finish;
  end

endmodule
